/* sv/cswa_pkg.sv */
// -----------------------------------------------------------------------------
// cswa_pkg
// Shared widths, register map, control types and command/status bundles for
// the current-sense window averager.
// -----------------------------------------------------------------------------
`default_nettype none

package cswa_pkg;

   // Field widths
   localparam int SMP_W      = 12;
   localparam int AVG_W      = 11;
   localparam int VDDA_W     = 12;
   localparam int GAIN_W     = 16;
   localparam int OHMS_W     = 16;
   localparam int MA_W       = 16;
   localparam int PROD_W     = SMP_W + MA_W;

   // Window length compare width (holds window lengths up to 8191)
   localparam int LEN_W      = 13;

   // Shared divider
   localparam int DIV_W      = 32;
   localparam int DIV_CNT_W  = $clog2(DIV_W);

   // Register port
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int IDX_W      = 3;

   // Full-scale numerator scale: millivolts to milliamps through microamps
   localparam logic [DIV_W-1:0] FS_SCALE = 32'd1000000;

   // Register reset values
   localparam logic [AVG_W-1:0]  RST_AVG_COUNT     = 11'd16;
   localparam logic [SMP_W-1:0]  RST_SAT_THRESHOLD = 12'd4000;
   localparam logic              RST_CAL_MODE      = 1'b0;
   localparam logic [VDDA_W-1:0] RST_VDDA_MV       = 12'd3300;
   localparam logic [GAIN_W-1:0] RST_GAIN          = 16'd1000;
   localparam logic [OHMS_W-1:0] RST_OHMS          = 16'd1000;

   // Register indexes
   typedef enum logic [IDX_W-1:0] {
      REG_AVG_COUNT     = 3'd0,
      REG_SAT_THRESHOLD = 3'd1,
      REG_CAL_MODE      = 3'd2,
      REG_VDDA_MV       = 3'd3,
      REG_GAIN          = 3'd4,
      REG_SENSE_OHMS    = 3'd5
   } cswa_reg_type;

   typedef struct packed {
      logic [AVG_W-1:0]  avg_count;
      logic [SMP_W-1:0]  sat_threshold;
      logic              calibrate_mode;
      logic [VDDA_W-1:0] vdda_mv;
      logic [GAIN_W-1:0] gain_ua_per_a;
      logic [OHMS_W-1:0] sense_ohms;
   } cswa_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_MEAN,
      ST_MEAN,
      ST_DIV_FS,
      ST_SCALE,
      ST_EMIT
   } cswa_state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic mean_start;
      logic div_step;
      logic latch_mean;
      logic fs_load;
      logic scale;
      logic emit;
   } cswa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic window_full;
      logic div_last;
      logic out_free;
   } cswa_status_type;

endpackage

`default_nettype wire

/* sv/cswa_req_if.sv */
// -----------------------------------------------------------------------------
// cswa_req_if
// Sample channel: valid/ready handshake carrying one raw ADC sample.
// -----------------------------------------------------------------------------
`default_nettype none

interface cswa_req_if;
   import cswa_pkg::*;

   logic             valid;
   logic             ready;
   logic [SMP_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* sv/cswa_rsp_if.sv */
// -----------------------------------------------------------------------------
// cswa_rsp_if
// Result channel: valid/ready handshake carrying one window result.
// -----------------------------------------------------------------------------
`default_nettype none

interface cswa_rsp_if;
   import cswa_pkg::*;

   logic             valid;
   logic             ready;
   logic [SMP_W-1:0] mean_counts;
   logic [MA_W-1:0]  current_ma;
   logic             saturated;
   logic             was_calibration;

   modport source (output valid, output mean_counts, output current_ma,
                   output saturated, output was_calibration, input ready);
   modport sink   (input valid, input mean_counts, input current_ma,
                   input saturated, input was_calibration, output ready);
endinterface

`default_nettype wire

/* sv/cswa_csr.sv */
// -----------------------------------------------------------------------------
// cswa_csr
// APB-style configuration registers with zero-wait-state reads and writes.
// -----------------------------------------------------------------------------
`default_nettype none

module cswa_csr
   import cswa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cswa_cfg_type           cfg
);

   cswa_cfg_type cfg_ff;
   cswa_reg_type reg_idx;
   logic         wr_en;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = cswa_reg_type'(paddr[ADDR_W-1:2]);
   assign cfg     = cfg_ff;

   // Write transfer updates the addressed register; unused slots drop the data
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.avg_count      <= RST_AVG_COUNT;
         cfg_ff.sat_threshold  <= RST_SAT_THRESHOLD;
         cfg_ff.calibrate_mode <= RST_CAL_MODE;
         cfg_ff.vdda_mv        <= RST_VDDA_MV;
         cfg_ff.gain_ua_per_a  <= RST_GAIN;
         cfg_ff.sense_ohms     <= RST_OHMS;
      end else if (wr_en) begin
         case (reg_idx)
            REG_AVG_COUNT:     cfg_ff.avg_count      <= pwdata[AVG_W-1:0];
            REG_SAT_THRESHOLD: cfg_ff.sat_threshold  <= pwdata[SMP_W-1:0];
            REG_CAL_MODE:      cfg_ff.calibrate_mode <= pwdata[0];
            REG_VDDA_MV:       cfg_ff.vdda_mv        <= pwdata[VDDA_W-1:0];
            REG_GAIN:          cfg_ff.gain_ua_per_a  <= pwdata[GAIN_W-1:0];
            REG_SENSE_OHMS:    cfg_ff.sense_ohms     <= pwdata[OHMS_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register, zero-extended
   always_comb begin
      case (reg_idx)
         REG_AVG_COUNT:     prdata = DATA_W'(cfg_ff.avg_count);
         REG_SAT_THRESHOLD: prdata = DATA_W'(cfg_ff.sat_threshold);
         REG_CAL_MODE:      prdata = DATA_W'(cfg_ff.calibrate_mode);
         REG_VDDA_MV:       prdata = DATA_W'(cfg_ff.vdda_mv);
         REG_GAIN:          prdata = DATA_W'(cfg_ff.gain_ua_per_a);
         REG_SENSE_OHMS:    prdata = DATA_W'(cfg_ff.sense_ohms);
         default:           prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

/* sv/cswa_ctrl.sv */
// -----------------------------------------------------------------------------
// cswa_ctrl
// Sequencer: accepts a sample, checks for the end of the window, then runs the
// mean division and, outside calibrate mode, the full-scale division and the
// scaling multiply, then the result transfer.
// -----------------------------------------------------------------------------
`default_nettype none

module cswa_ctrl
   import cswa_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            calibrate,
   input  wire cswa_status_type status,
   output logic                 req_ready,
   output cswa_cmd_type         cmd
);

   cswa_state_type state_ff;
   cswa_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.window_full) begin
               cmd.mean_start = 1'b1;
               state_in       = ST_DIV_MEAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            cmd.latch_mean = 1'b1;
            if (calibrate) begin
               state_in = ST_EMIT;
            end else begin
               cmd.fs_load = 1'b1;
               state_in    = ST_DIV_FS;
            end
         end
         ST_DIV_FS: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // Hold until the output register is free
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/cswa_dp.sv */
// -----------------------------------------------------------------------------
// cswa_dp
// Datapath: window accumulator, saturation latch, zero offset, shared
// radix-2 restoring divider, scaling multiplier and result register.
// -----------------------------------------------------------------------------
`default_nettype none

module cswa_dp
   import cswa_pkg::*;
#(
   parameter int MAX_WINDOW = 1024,
   parameter int CAL_WINDOW = 256
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cswa_cfg_type     cfg,
   input  wire cswa_cmd_type     cmd,
   input  wire logic [SMP_W-1:0] sample,
   input  wire logic             rsp_ready,
   output cswa_status_type       status,
   output logic                  rsp_valid,
   output logic      [SMP_W-1:0] rsp_mean_counts,
   output logic      [MA_W-1:0]  rsp_current_ma,
   output logic                  rsp_saturated,
   output logic                  rsp_was_calibration
);

   localparam int WIN_MAX = (MAX_WINDOW > CAL_WINDOW) ? MAX_WINDOW : CAL_WINDOW;
   localparam int CNT_W   = $clog2(WIN_MAX + 1);
   localparam int SUM_W   = SMP_W + CNT_W;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WINDOW);
   localparam logic [LEN_W-1:0] CAL_LEN = LEN_W'(CAL_WINDOW);
   localparam logic [LEN_W-1:0] ONE_LEN = LEN_W'(1);

   // Window state
   logic [SUM_W-1:0]     sum_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 sat_ff;
   logic [SMP_W-1:0]     offset_ff;

   // Divider
   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     dvs_ff;
   logic [DIV_CNT_W-1:0] step_ff;
   logic [DIV_W:0]       shifted;
   logic [DIV_W+1:0]     diff;

   // Post-processing
   logic [SMP_W-1:0]     mean_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [SMP_W-1:0]     corr;
   logic [MA_W-1:0]      full_scale;

   // Result register
   logic                 out_valid_ff;
   logic [SMP_W-1:0]     out_mean_ff;
   logic [MA_W-1:0]      out_ma_ff;
   logic                 out_sat_ff;
   logic                 out_cal_ff;

   logic [LEN_W-1:0]     avg_len;
   logic [LEN_W-1:0]     avg_ext;
   logic [LEN_W-1:0]     win_len;

   // Window length: clamp avg_count to 1..MAX_WINDOW, fixed length when calibrating
   assign avg_ext = LEN_W'(cfg.avg_count);
   always_comb begin
      if (avg_ext == '0) begin
         avg_len = ONE_LEN;
      end else if (avg_ext > MAX_LEN) begin
         avg_len = MAX_LEN;
      end else begin
         avg_len = avg_ext;
      end
   end
   assign win_len = cfg.calibrate_mode ? CAL_LEN : avg_len;

   assign status.window_full = (LEN_W'(count_ff) >= win_len);
   assign status.div_last    = (step_ff == DIV_CNT_W'(DIV_W - 1));
   assign status.out_free    = !out_valid_ff || rsp_ready;

   // Accumulate samples; clear the window when its result is loaded for output
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         count_ff  <= '0;
         sat_ff    <= 1'b0;
         offset_ff <= '0;
      end else begin
         if (cmd.take) begin
            sum_ff   <= sum_ff + SUM_W'(sample);
            count_ff <= count_ff + CNT_W'(1);
            if (sample >= cfg.sat_threshold) begin
               sat_ff <= 1'b1;
            end
         end else if (cmd.emit) begin
            sum_ff   <= '0;
            count_ff <= '0;
            sat_ff   <= 1'b0;
         end
         if (cmd.emit && cfg.calibrate_mode) begin
            offset_ff <= mean_ff;
         end
      end
   end

   // Restoring divider: one quotient bit per step
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_ff @(posedge clock) begin
      if (cmd.mean_start) begin
         rem_ff  <= '0;
         quo_ff  <= DIV_W'(sum_ff);
         dvs_ff  <= DIV_W'(count_ff);
         step_ff <= '0;
      end else if (cmd.fs_load) begin
         rem_ff  <= '0;
         quo_ff  <= DIV_W'(DIV_W'(cfg.vdda_mv) * FS_SCALE);
         dvs_ff  <= DIV_W'(DIV_W'(cfg.gain_ua_per_a) * DIV_W'(cfg.sense_ohms));
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + DIV_CNT_W'(1);
         if (!diff[DIV_W+1]) begin
            rem_ff <= diff[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   // Full scale: zero for a zero divisor, saturate to 16 bits
   always_comb begin
      if (dvs_ff == '0) begin
         full_scale = '0;
      end else if (|quo_ff[DIV_W-1:MA_W]) begin
         full_scale = '1;
      end else begin
         full_scale = quo_ff[MA_W-1:0];
      end
   end

   // Offset-corrected mean, floored at zero
   assign corr = (mean_ff > offset_ff) ? (mean_ff - offset_ff) : '0;

   // Latch the mean, then scale to milliamps
   always_ff @(posedge clock) begin
      if (cmd.latch_mean) begin
         mean_ff <= quo_ff[SMP_W-1:0];
      end
      if (cmd.scale) begin
         prod_ff <= PROD_W'(corr) * PROD_W'(full_scale);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (cfg.calibrate_mode) begin
            out_mean_ff <= mean_ff;
            out_ma_ff   <= '0;
            out_sat_ff  <= 1'b0;
            out_cal_ff  <= 1'b1;
         end else begin
            out_mean_ff <= corr;
            out_ma_ff   <= prod_ff[PROD_W-1:SMP_W];
            out_sat_ff  <= sat_ff;
            out_cal_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_mean_counts     = out_mean_ff;
   assign rsp_current_ma      = out_ma_ff;
   assign rsp_saturated       = out_sat_ff;
   assign rsp_was_calibration = out_cal_ff;

endmodule

`default_nettype wire

/* sv/current_sense_window_averager.sv */
// -----------------------------------------------------------------------------
// current_sense_window_averager
// Boxcar averager for current-sense ADC samples with zero-offset calibration.
// -----------------------------------------------------------------------------
// Samples are summed over a window of avg_count samples (1..MAX_WINDOW) or,
// with calibrate_mode set, CAL_WINDOW samples; the window length and mode are
// checked after every sample, and one result leaves when the window closes.
// A sample that does not close a window is transferred and then checked
// against the window length. The closing sample then runs the shared
// 32-step radix-2 divider: one pass forms the mean and, in measure mode only,
// a second pass forms the full-scale factor vdda*1e6/(gain*ohms), followed by
// one scaling multiply. The result sits in an output register, so the next
// window fills while it waits; a second window end stalls only until that
// register frees. The user must write configuration through the APB port
// only while the block is idle; the block itself does not enforce this.
// -----------------------------------------------------------------------------
`default_nettype none

module current_sense_window_averager
   import cswa_pkg::*;
#(
   parameter int MAX_WINDOW = 1024,
   parameter int CAL_WINDOW = 256
)(
   input  wire logic              clock,
   input  wire logic              reset,
   cswa_req_if.sink               req_chan,
   cswa_rsp_if.source             rsp_chan,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready
);

   cswa_cfg_type    cfg;
   cswa_cmd_type    cmd;
   cswa_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   logic [SMP_W-1:0] rsp_mean_counts;
   logic [MA_W-1:0]  rsp_current_ma;
   logic            rsp_saturated;
   logic            rsp_was_calibration;

   cswa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cswa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .calibrate (cfg.calibrate_mode),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   cswa_dp #(
      .MAX_WINDOW (MAX_WINDOW),
      .CAL_WINDOW (CAL_WINDOW)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .sample              (req_chan.sample),
      .rsp_ready           (rsp_chan.ready),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_mean_counts     (rsp_mean_counts),
      .rsp_current_ma      (rsp_current_ma),
      .rsp_saturated       (rsp_saturated),
      .rsp_was_calibration (rsp_was_calibration)
   );

   // Drive the channel ports
   assign req_chan.ready           = req_ready;
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.mean_counts     = rsp_mean_counts;
   assign rsp_chan.current_ma      = rsp_current_ma;
   assign rsp_chan.saturated       = rsp_saturated;
   assign rsp_chan.was_calibration = rsp_was_calibration;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// -----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the current-sense window averager.
// -----------------------------------------------------------------------------
// A clocked driver feeds ADC samples from a queue. An in-bench predictor keeps
// its own copy of the registers and of the window state. On every sample
// transfer it computes the window result that the sample closes, if any. A
// clocked monitor compares each result transfer, field by field, with the
// oldest prediction. Registers are written over APB only between phases,
// once every predicted result has arrived. Both channels idle at random.
// The run has one long result-side hold-off and a watchdog on stalled traffic.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import cswa_pkg::*;

   localparam int WINDOW_MAX      = 1024;
   localparam int WINDOW_CAL      = 256;
   localparam int SUM_W           = SMP_W + 10;
   localparam int MA_DIVISOR      = 4096;
   localparam int TARGET_SAMPLES  = 1950;
   localparam int STALL_LIMIT     = 3000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 100;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int IDLE_PCT        = 28;
   localparam int MAX_PRINTED     = 200;

   // Register indexes with no register behind them
   localparam logic [IDX_W-1:0] SPARE_REG_LO = 3'd6;
   localparam logic [IDX_W-1:0] SPARE_REG_HI = 3'd7;

   typedef struct packed {
      logic [SMP_W-1:0] mean_counts;
      logic [MA_W-1:0]  current_ma;
      logic             saturated;
      logic             was_calibration;
   } window_result_type;

   typedef enum int {MIX_UNIFORM, MIX_LOW, MIX_HIGH} sample_mix_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   cswa_req_if req_bus ();
   cswa_rsp_if rsp_bus ();

   current_sense_window_averager #(
      .MAX_WINDOW (WINDOW_MAX),
      .CAL_WINDOW (WINDOW_CAL)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Shadow registers and window state of the predictor
   cswa_cfg_type       cfg;
   logic [SUM_W-1:0]   acc_sum;
   logic [AVG_W-1:0]   acc_count;
   logic               acc_sat;
   logic [SMP_W-1:0]   cal_offset;

   logic [SMP_W-1:0]   pending_samples[$];
   window_result_type  expected_results[$];

   int unsigned err_count        = 0;
   int unsigned cycle_count      = 0;
   int unsigned quiet_cycles     = 0;
   int unsigned samples_planned  = 0;
   int unsigned samples_accepted = 0;
   int unsigned hold_requests    = 0;
   int unsigned hold_served      = 0;
   int unsigned hold_left        = 0;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic logic [MA_W-1:0] full_scale_ma();
      logic [63:0] den;
      logic [63:0] fs;
      den = 64'(cfg.gain_ua_per_a) * 64'(cfg.sense_ohms);
      if (den == 64'd0) return '0;
      fs = (64'(cfg.vdda_mv) * 64'(FS_SCALE)) / den;
      return (fs > 64'd65535) ? {MA_W{1'b1}} : fs[MA_W-1:0];
   endfunction

   function automatic logic [LEN_W-1:0] window_len();
      if (cfg.calibrate_mode) return LEN_W'(WINDOW_CAL);
      if (cfg.avg_count == '0) return LEN_W'(1);
      if (cfg.avg_count > WINDOW_MAX) return LEN_W'(WINDOW_MAX);
      return LEN_W'(cfg.avg_count);
   endfunction

   // Add one sample to the window; queue a result when the window closes
   function automatic void predict_sample(input logic [SMP_W-1:0] s);
      logic [SMP_W-1:0]  mean;
      logic [SMP_W-1:0]  corr;
      logic [31:0]       ma;
      window_result_type r;
      acc_sum   = acc_sum + SUM_W'(s);
      acc_count = acc_count + AVG_W'(1);
      if (s >= cfg.sat_threshold) acc_sat = 1'b1;
      if (LEN_W'(acc_count) < window_len()) return;
      mean = SMP_W'(acc_sum / SUM_W'(acc_count));
      if (cfg.calibrate_mode) begin
         cal_offset        = mean;
         r.mean_counts     = mean;
         r.current_ma      = '0;
         r.saturated       = 1'b0;
         r.was_calibration = 1'b1;
      end else begin
         corr              = (mean > cal_offset) ? mean - cal_offset : '0;
         ma                = (32'(corr) * 32'(full_scale_ma())) / MA_DIVISOR;
         r.mean_counts     = corr;
         r.current_ma      = ma[MA_W-1:0];
         r.saturated       = acc_sat;
         r.was_calibration = 1'b0;
      end
      expected_results.push_back(r);
      acc_sum   = '0;
      acc_count = '0;
      acc_sat   = 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (err_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
      err_count++;
   endtask

   task automatic check_result(input window_result_type got);
      window_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result mean=%0d ma=%0d sat=%0b cal=%0b",
                                   got.mean_counts, got.current_ma, got.saturated,
                                   got.was_calibration));
         return;
      end
      want = expected_results.pop_front();
      if (got.mean_counts !== want.mean_counts)
         report_mismatch($sformatf("mean_counts %0d, expected %0d",
                                   got.mean_counts, want.mean_counts));
      if (got.current_ma !== want.current_ma)
         report_mismatch($sformatf("current_ma %0d, expected %0d",
                                   got.current_ma, want.current_ma));
      if (got.saturated !== want.saturated)
         report_mismatch($sformatf("saturated %0b, expected %0b",
                                   got.saturated, want.saturated));
      if (got.was_calibration !== want.was_calibration)
         report_mismatch($sformatf("was_calibration %0b, expected %0b",
                                   got.was_calibration, want.was_calibration));
   endtask

   // ------------------------------------------------------------------
   // Random helpers
   // ------------------------------------------------------------------
   // Idle about IDLE_PCT percent of cycles, except in a recurring calm stretch
   function automatic logic take_break();
      if ((cycle_count % 9000) >= 7000) return 1'b0;
      return ($urandom_range(0, 99) < IDLE_PCT);
   endfunction

   function automatic int unsigned pick_value(input int unsigned hi);
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return hi;
         2, 3:    return $urandom_range(1, 64);
         default: return $urandom_range(0, hi);
      endcase
   endfunction

   function automatic logic [SMP_W-1:0] next_sample(input sample_mix_type mix);
      int t;
      case (mix)
         MIX_LOW:  return SMP_W'($urandom_range(0, 400));
         MIX_HIGH: begin
            if ($urandom_range(0, 1)) return {SMP_W{1'b1}};
            return SMP_W'($urandom_range(2048, 4095));
         end
         default: begin
            case ($urandom_range(0, 7))
               0:       return '0;
               1:       return {SMP_W{1'b1}};
               2, 3: begin
                  // land on or around the saturation threshold
                  t = int'(cfg.sat_threshold) + int'($urandom_range(0, 4)) - 2;
                  if (t < 0) t = 0;
                  if (t > 4095) t = 4095;
                  return SMP_W'(t);
               end
               default: return SMP_W'($urandom_range(0, 4095));
            endcase
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus tasks
   // ------------------------------------------------------------------
   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_AVG_COUNT:     cfg.avg_count      = value[AVG_W-1:0];
         REG_SAT_THRESHOLD: cfg.sat_threshold  = value[SMP_W-1:0];
         REG_CAL_MODE:      cfg.calibrate_mode = value[0];
         REG_VDDA_MV:       cfg.vdda_mv        = value[VDDA_W-1:0];
         REG_GAIN:          cfg.gain_ua_per_a  = value[GAIN_W-1:0];
         REG_SENSE_OHMS:    cfg.sense_ohms     = value[OHMS_W-1:0];
         default:           ;
      endcase
   endtask

   task automatic queue_value(input logic [SMP_W-1:0] v);
      pending_samples.push_back(v);
      samples_planned++;
   endtask

   task automatic queue_samples(input int n, input sample_mix_type mix);
      repeat (n) queue_value(next_sample(mix));
   endtask

   // Hold until every sample is taken and every result is back, then settle
   task automatic wait_quiet();
      while (samples_accepted != samples_planned || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Measure-mode setting with a short window and random scaling
   task automatic write_measure_cfg();
      int unsigned n;
      case ($urandom_range(0, 3))
         0:       n = $urandom_range(0, 2);
         1:       n = $urandom_range(17, 64);
         default: n = $urandom_range(3, 16);
      endcase
      csr_write(REG_CAL_MODE, 32'(0));
      csr_write(REG_AVG_COUNT, 32'(n));
      csr_write(REG_SAT_THRESHOLD, 32'(pick_value(4095)));
      csr_write(REG_VDDA_MV, 32'(pick_value(4095)));
      csr_write(REG_GAIN, 32'(pick_value(65535)));
      csr_write(REG_SENSE_OHMS, 32'(pick_value(65535)));
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Sample driver: offer queued samples, predict on each transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_sample(req_bus.sample);
            samples_accepted++;
         end
         // hold an offered sample until it transfers
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_samples.size() > 0 && !take_break()) begin
               req_bus.valid  <= 1'b1;
               req_bus.sample <= pending_samples.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: check transfers, stall at random or on request
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result('{rsp_bus.mean_counts, rsp_bus.current_ma,
                           rsp_bus.saturated, rsp_bus.was_calibration});
         end
         if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !take_break();
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run when no transfer happens for too long
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      int phase;
      int unsigned pick;

      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      rsp_bus.ready  = 1'b0;

      cfg.avg_count      = RST_AVG_COUNT;
      cfg.sat_threshold  = RST_SAT_THRESHOLD;
      cfg.calibrate_mode = RST_CAL_MODE;
      cfg.vdda_mv        = RST_VDDA_MV;
      cfg.gain_ua_per_a  = RST_GAIN;
      cfg.sense_ohms     = RST_OHMS;
      acc_sum            = '0;
      acc_count          = '0;
      acc_sat            = 1'b0;
      cal_offset         = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Single-sample windows, threshold at the top of the range
      csr_write(REG_AVG_COUNT, 32'(1));
      csr_write(REG_SAT_THRESHOLD, 32'(4095));
      queue_value(12'd4095);
      queue_value(12'd0);
      queue_value(12'd4094);
      wait_quiet();

      // Zero gain gives zero full scale; zero window length acts as one;
      // writes to spare indexes change nothing
      csr_write(REG_GAIN, 32'(0));
      csr_write(REG_AVG_COUNT, 32'(0));
      csr_write(SPARE_REG_LO, 32'hFFFF_FFFF);
      csr_write(SPARE_REG_HI, 32'h0000_0001);
      queue_value(12'd4095);
      queue_value(12'd2048);
      wait_quiet();

      // Full scale saturates; threshold zero flags every window
      csr_write(REG_GAIN, 32'(1));
      csr_write(REG_SENSE_OHMS, 32'(1));
      csr_write(REG_VDDA_MV, 32'(4095));
      csr_write(REG_SAT_THRESHOLD, 32'(0));
      csr_write(REG_AVG_COUNT, 32'(2));
      queue_value(12'd4095);
      queue_value(12'd4095);
      queue_value(12'd1);
      queue_value(12'd2);
      wait_quiet();

      // Oversized window, then shrink it below the samples already summed
      csr_write(REG_VDDA_MV, 32'(0));
      csr_write(REG_SENSE_OHMS, 32'(65535));
      csr_write(REG_AVG_COUNT, 32'(2047));
      queue_value(12'd7);
      queue_value(12'd8);
      queue_value(12'd9);
      wait_quiet();
      csr_write(REG_AVG_COUNT, 32'(2));
      queue_value(12'd4095);
      wait_quiet();

      // Largest gain and resistor: full scale rounds down to zero
      csr_write(REG_VDDA_MV, 32'(4095));
      csr_write(REG_GAIN, 32'(65535));
      csr_write(REG_AVG_COUNT, 32'(3));
      queue_value(12'd0);
      queue_value(12'd4095);
      queue_value(12'd100);
      wait_quiet();

      // Random phases, each ending with a pause until all results are back
      phase = 0;
      while (samples_planned < TARGET_SAMPLES) begin
         if (phase == 0) begin
            // one full calibration window to set a nonzero offset
            csr_write(REG_CAL_MODE, 32'(1));
            queue_samples(WINDOW_CAL, MIX_LOW);
         end else if (phase == 1) begin
            // result side holds off while samples are still being offered
            write_measure_cfg();
            csr_write(REG_AVG_COUNT, 32'(1));
            queue_samples(40, MIX_UNIFORM);
            hold_requests++;
         end else if (phase == 4) begin
            // close any open window, then fill the largest window from empty
            csr_write(REG_CAL_MODE, 32'(0));
            if (acc_count != '0) begin
               csr_write(REG_AVG_COUNT, 32'(1));
               queue_samples(1, MIX_UNIFORM);
               wait_quiet();
            end
            csr_write(REG_AVG_COUNT, 32'(2047));
            queue_samples(WINDOW_MAX, MIX_HIGH);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               write_measure_cfg();
               queue_samples($urandom_range(1, 60), MIX_UNIFORM);
            end else if (pick < 75) begin
               csr_write(REG_CAL_MODE, 32'(1));
               queue_samples($urandom_range(1, 300), MIX_LOW);
            end else if (pick < 90) begin
               // new window length with the current window left open
               csr_write(REG_AVG_COUNT, 32'($urandom_range(0, 40)));
               queue_samples($urandom_range(1, 30), MIX_UNIFORM);
            end else begin
               csr_write(REG_CAL_MODE, 32'(0));
               csr_write(REG_SAT_THRESHOLD, 32'(pick_value(4095)));
               queue_samples($urandom_range(1, 50), MIX_UNIFORM);
            end
         end
         wait_quiet();
         phase++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
